// File: sv/wto_pkg.sv
package wto_pkg;

  // Default widths of the counter and timestamp words
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int TIME_WIDTH_DEF  = 32;

  // Configuration register widths
  localparam int TPM_W      = 16;
  localparam int WB_W       = 12;
  localparam int MAXS_W     = 14;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // Configuration reset values
  localparam logic [TPM_W-1:0]  TPM_RESET  = TPM_W'(280);
  localparam logic [WB_W-1:0]   WB_RESET   = WB_W'(330);
  localparam logic [MAXS_W-1:0] MAXS_RESET = MAXS_W'(1000);

  // Result field widths
  localparam int SPEED_W = 15;
  localparam int TURN_W  = 21;

  // Scale factors: mm over us for speed, mrad over us for turn rate
  localparam int SCALE_W = 40;
  localparam logic [SCALE_W-1:0] SCALE_SPEED = SCALE_W'(64'd1000000000);
  localparam logic [SCALE_W-1:0] SCALE_TURN  = SCALE_W'(64'd1000000000000);

  // Shift-add multiply runs one scale bit per cycle
  localparam int MUL_STEPS = SCALE_W;

  // Quotient bits: enough to exceed both turn-rate caps and the speed limit
  localparam int QUOT_W = 22;
  localparam logic [QUOT_W-1:0] TURN_POS_CAP = QUOT_W'(1048575);
  localparam logic [QUOT_W-1:0] TURN_NEG_CAP = QUOT_W'(1048576);

  // Step counter covers both the multiply and the divide sequences
  localparam int CNT_W = $clog2(MUL_STEPS);

  typedef enum logic [1:0] {
    ST_STORED = 2'd0,
    ST_VALID  = 2'd1,
    ST_DT_BAD = 2'd2,
    ST_FAST   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TPM  = 2'd0,
    CFG_WB   = 2'd1,
    CFG_MAXS = 2'd2
  } cfg_index_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic load;
    logic mul_step;
    logic div_start;
    logic div_step;
    logic check;
    logic turn_start;
    logic commit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic first;
    logic dt_bad;
    logic too_fast;
    logic out_free;
  } dp_stat_t;

endpackage

// File: sv/wto_ctrl.sv
module wto_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  wto_pkg::dp_stat_t    stat,
  output wto_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_LOAD   = 7'b0000010,
    S_MUL    = 7'b0000100,
    S_DIVI   = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_CHECK  = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t                    state;
  state_t                    state_next;
  logic [wto_pkg::CNT_W-1:0] cnt;
  logic [wto_pkg::CNT_W-1:0] cnt_next;
  logic                      turn_phase;
  logic                      turn_phase_next;

  // Sequence one word: speed pass, then turn-rate pass, unless the word is a first sample, has a bad dt or is too fast
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    turn_phase_next = turn_phase;
    cmd             = '0;
    in_stall        = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load = 1'b1;
        if (stat.first || stat.dt_bad) begin
          state_next = S_FINISH;
        end else begin
          cnt_next        = '0;
          turn_phase_next = 1'b0;
          state_next      = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt + wto_pkg::CNT_W'(1);
        if (cnt == wto_pkg::CNT_W'(wto_pkg::MUL_STEPS - 1)) begin
          state_next = S_DIVI;
        end
      end
      S_DIVI: begin
        cmd.div_start = 1'b1;
        cnt_next      = '0;
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + wto_pkg::CNT_W'(1);
        if (cnt == wto_pkg::CNT_W'(wto_pkg::QUOT_W - 1)) begin
          state_next = turn_phase ? S_FINISH : S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (stat.too_fast) begin
          state_next = S_FINISH;
        end else begin
          cmd.turn_start  = 1'b1;
          cnt_next        = '0;
          turn_phase_next = 1'b1;
          state_next      = S_MUL;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      turn_phase <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      turn_phase <= turn_phase_next;
    end
  end

endmodule

// File: sv/wto_dp.sv
module wto_dp #(
  parameter int COUNT_WIDTH = wto_pkg::COUNT_WIDTH_DEF,
  parameter int TIME_WIDTH  = wto_pkg::TIME_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  wto_pkg::ctrl_cmd_t                cmd,
  output wto_pkg::dp_stat_t                 stat,
  input  logic [TIME_WIDTH-1:0]             time_us,
  input  logic [COUNT_WIDTH-1:0]            left_count,
  input  logic [COUNT_WIDTH-1:0]            right_count,
  input  logic                              left_backward,
  input  logic                              right_backward,
  input  logic                              cfg_write,
  input  logic [wto_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wto_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        status,
  output logic [wto_pkg::SPEED_W-1:0]       speed_mm_s,
  output logic [wto_pkg::TURN_W-1:0]        turn_rate_mrad_s,
  output logic                              reversing
);

  localparam int MAG_W = COUNT_WIDTH + 1;
  localparam int SUM_W = MAG_W + 1;
  localparam int NUM_W = MAG_W + wto_pkg::SCALE_W;
  localparam int DEN_W = TIME_WIDTH + wto_pkg::TPM_W + wto_pkg::WB_W - 1;
  localparam int DB_W  = wto_pkg::TPM_W + 1;
  localparam int QW    = wto_pkg::QUOT_W;
  localparam int DIV_W = (NUM_W > DEN_W + QW - 1) ? NUM_W : DEN_W + QW - 1;

  // Configuration registers
  logic [wto_pkg::TPM_W-1:0]  tpm;
  logic [wto_pkg::WB_W-1:0]   wb;
  logic [wto_pkg::MAXS_W-1:0] max_speed;
  logic [wto_pkg::TPM_W-1:0]  tpm_eff;
  logic [wto_pkg::WB_W-1:0]   wb_eff;

  // Odometry state
  logic                   have_prev;
  logic [TIME_WIDTH-1:0]  prev_time;
  logic [COUNT_WIDTH-1:0] prev_left;
  logic [COUNT_WIDTH-1:0] prev_right;
  logic                   rev_flag;

  // Captured word
  logic [TIME_WIDTH-1:0]  cap_time;
  logic [COUNT_WIDTH-1:0] cap_left;
  logic [COUNT_WIDTH-1:0] cap_right;
  logic                   cap_lb;
  logic                   cap_rb;

  // Deltas
  logic [TIME_WIDTH-1:0]  dt;
  logic [COUNT_WIDTH-1:0] raw_l;
  logic [COUNT_WIDTH-1:0] raw_r;
  logic [MAG_W-1:0]       dl_ext;
  logic [MAG_W-1:0]       dr_ext;
  logic [MAG_W-1:0]       dl;
  logic [MAG_W-1:0]       dr;
  logic [SUM_W-1:0]       sum;
  logic [SUM_W-1:0]       dif;
  logic [SUM_W-1:0]       sum_abs;
  logic [SUM_W-1:0]       dif_abs;

  // Per-word registers
  wto_pkg::status_t            status_q;
  logic                        sum_neg_q;
  logic                        dif_neg_q;
  logic [MAG_W-1:0]            dif_mag_q;
  logic                        rev_q;
  logic [wto_pkg::SPEED_W-1:0] speed_q;

  // Shift-add multipliers
  logic [NUM_W-1:0]            num_acc;
  logic [NUM_W-1:0]            num_a;
  logic [wto_pkg::SCALE_W-1:0] num_b;
  logic [DEN_W-1:0]            den_acc;
  logic [DEN_W-1:0]            den_a;
  logic [DB_W-1:0]             den_b;

  // Restoring divider
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsr;
  logic [QW-1:0]    quot;

  // Result selection
  logic [QW-1:0]   max_ext;
  logic [QW-1:0]   tcap;
  logic [QW-1:0]   tmag;
  logic [QW-1:0]   tval;
  logic            is_valid;
  logic            upd_state;

  assign tpm_eff = (tpm == '0) ? wto_pkg::TPM_W'(1) : tpm;
  assign wb_eff  = (wb == '0) ? wto_pkg::WB_W'(1) : wb;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tpm       <= wto_pkg::TPM_RESET;
      wb        <= wto_pkg::WB_RESET;
      max_speed <= wto_pkg::MAXS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        wto_pkg::CFG_TPM:  tpm       <= cfg_data[wto_pkg::TPM_W-1:0];
        wto_pkg::CFG_WB:   wb        <= cfg_data[wto_pkg::WB_W-1:0];
        wto_pkg::CFG_MAXS: max_speed <= cfg_data[wto_pkg::MAXS_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the incoming word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_time  <= time_us;
      cap_left  <= left_count;
      cap_right <= right_count;
      cap_lb    <= left_backward;
      cap_rb    <= right_backward;
    end
  end

  // Signed deltas, negated for a backward wheel
  always_comb begin
    dt      = cap_time - prev_time;
    raw_l   = cap_left - prev_left;
    raw_r   = cap_right - prev_right;
    dl_ext  = {raw_l[COUNT_WIDTH-1], raw_l};
    dr_ext  = {raw_r[COUNT_WIDTH-1], raw_r};
    dl      = cap_lb ? (MAG_W'(0) - dl_ext) : dl_ext;
    dr      = cap_rb ? (MAG_W'(0) - dr_ext) : dr_ext;
    sum     = {dl[MAG_W-1], dl} + {dr[MAG_W-1], dr};
    dif     = {dr[MAG_W-1], dr} - {dl[MAG_W-1], dl};
    sum_abs = sum[SUM_W-1] ? (SUM_W'(0) - sum) : sum;
    dif_abs = dif[SUM_W-1] ? (SUM_W'(0) - dif) : dif;
  end

  assign stat.first    = !have_prev;
  assign stat.dt_bad   = (dt == '0) || dt[TIME_WIDTH-1];
  assign stat.out_free = !out_valid || !out_stall;

  // Classify the word and hold its signs and magnitudes
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (!have_prev) begin
        status_q <= wto_pkg::ST_STORED;
      end else if (stat.dt_bad) begin
        status_q <= wto_pkg::ST_DT_BAD;
      end else begin
        status_q <= wto_pkg::ST_VALID;
      end
      sum_neg_q <= sum[SUM_W-1];
      dif_neg_q <= dif[SUM_W-1];
      dif_mag_q <= dif_abs[MAG_W-1:0];
      rev_q     <= cap_lb && cap_rb;
    end else if (cmd.check) begin
      if (stat.too_fast) begin
        status_q <= wto_pkg::ST_FAST;
      end else begin
        speed_q <= sum_neg_q ? (wto_pkg::SPEED_W'(0) - quot[wto_pkg::SPEED_W-1:0])
                             : quot[wto_pkg::SPEED_W-1:0];
      end
    end
  end

  // Multiply numerator and denominator, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_acc <= '0;
      num_a   <= NUM_W'(sum_abs[MAG_W-1:0]);
      num_b   <= wto_pkg::SCALE_SPEED;
      den_acc <= '0;
      den_a   <= DEN_W'(dt);
      den_b   <= {tpm_eff, 1'b0};
    end else if (cmd.turn_start) begin
      num_acc <= '0;
      num_a   <= NUM_W'(dif_mag_q);
      num_b   <= wto_pkg::SCALE_TURN;
      den_acc <= '0;
      den_a   <= den_acc >> 1;
      den_b   <= DB_W'(wb_eff);
    end else if (cmd.mul_step) begin
      if (num_b[0]) begin
        num_acc <= num_acc + num_a;
      end
      if (den_b[0]) begin
        den_acc <= den_acc + den_a;
      end
      num_a <= num_a << 1;
      num_b <= num_b >> 1;
      den_a <= den_a << 1;
      den_b <= den_b >> 1;
    end
  end

  // Divide, one quotient bit per cycle, most significant first
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem  <= DIV_W'(num_acc);
      dsr  <= DIV_W'(den_acc) << (QW - 1);
      quot <= '0;
    end else if (cmd.div_step) begin
      if (rem >= dsr) begin
        rem  <= rem - dsr;
        quot <= {quot[QW-2:0], 1'b1};
      end else begin
        quot <= {quot[QW-2:0], 1'b0};
      end
      dsr <= dsr >> 1;
    end
  end

  // Speed limit test: exact quotient above the limit
  assign max_ext       = QW'(max_speed);
  assign stat.too_fast = (quot > max_ext) || ((quot == max_ext) && (rem != '0));

  // Saturate turn rate at its signed range
  always_comb begin
    tcap = dif_neg_q ? wto_pkg::TURN_NEG_CAP : wto_pkg::TURN_POS_CAP;
    tmag = (quot > tcap) ? tcap : quot;
    tval = dif_neg_q ? (QW'(0) - tmag) : tmag;
  end

  assign is_valid  = (status_q == wto_pkg::ST_VALID);
  assign upd_state = is_valid || (status_q == wto_pkg::ST_FAST);

  // Commit state and load the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev  <= 1'b0;
      prev_time  <= '0;
      prev_left  <= '0;
      prev_right <= '0;
      rev_flag   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
        if (status_q == wto_pkg::ST_STORED) begin
          have_prev <= 1'b1;
        end
        if ((status_q == wto_pkg::ST_STORED) || upd_state) begin
          prev_time  <= cap_time;
          prev_left  <= cap_left;
          prev_right <= cap_right;
        end
        if (upd_state) begin
          rev_flag <= rev_q;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status           <= status_q;
      speed_mm_s       <= is_valid ? speed_q : '0;
      turn_rate_mrad_s <= is_valid ? tval[wto_pkg::TURN_W-1:0] : '0;
      reversing        <= upd_state ? rev_q : rev_flag;
    end
  end

endmodule

// File: sv/wheel_tick_odometry.sv
// A first sample or a non-positive dt goes from the load step straight to the result,
// a too-fast sample runs the speed pass only and a valid one also the turn-rate pass;
// the result waits in the finish state while the output stalls. Words are handled one
// at a time: the next word is taken once the result is registered. Each pass is a
// 40-step shift-add multiply followed by a 22-step restoring divide.
// Reset (rst, synchronous): clears the odometry state and loads default registers.
module wheel_tick_odometry #(
  parameter int COUNT_WIDTH = wto_pkg::COUNT_WIDTH_DEF,
  parameter int TIME_WIDTH  = wto_pkg::TIME_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [TIME_WIDTH-1:0]             time_us,
  input  logic [COUNT_WIDTH-1:0]            left_count,
  input  logic [COUNT_WIDTH-1:0]            right_count,
  input  logic                              left_backward,
  input  logic                              right_backward,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        status,
  output logic [wto_pkg::SPEED_W-1:0]       speed_mm_s,
  output logic [wto_pkg::TURN_W-1:0]        turn_rate_mrad_s,
  output logic                              reversing,
  input  logic                              cfg_write,
  input  logic [wto_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wto_pkg::CFG_DATA_W-1:0]    cfg_data
);

  wto_pkg::ctrl_cmd_t cmd;
  wto_pkg::dp_stat_t  stat;

  wto_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  wto_dp #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .time_us          (time_us),
    .left_count       (left_count),
    .right_count      (right_count),
    .left_backward    (left_backward),
    .right_backward   (right_backward),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .speed_mm_s       (speed_mm_s),
    .turn_rate_mrad_s (turn_rate_mrad_s),
    .reversing        (reversing)
  );

endmodule

// File: test/tb_wheel_tick_odometry.sv
`timescale 1ns / 100ps

module tb_wheel_tick_odometry;

  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 150;
  localparam int STALL_LIMIT   = 4000;
  localparam int PHASE_WORDS   = 88;

  // One expected odometry report
  typedef struct {
    wto_pkg::status_t            status;
    logic [wto_pkg::SPEED_W-1:0] speed;
    logic [wto_pkg::TURN_W-1:0]  turn;
    logic                        reversing;
  } motion_t;

  // Tracks register settings and odometry state, predicts each report in order
  class odometry_board;
    logic [15:0] tpm;
    logic [11:0] wb;
    logic [13:0] max_speed;
    logic        have_prev;
    logic [31:0] last_time;
    logic [31:0] last_left;
    logic [31:0] last_right;
    logic        rev;
    motion_t     expected_motion[$];
    int          errors;
    int          status_seen[4];

    function new();
      tpm        = wto_pkg::TPM_RESET;
      wb         = wto_pkg::WB_RESET;
      max_speed  = wto_pkg::MAXS_RESET;
      have_prev  = 1'b0;
      last_time  = '0;
      last_left  = '0;
      last_right = '0;
      rev        = 1'b0;
      errors     = 0;
      foreach (status_seen[k]) status_seen[k] = 0;
    endfunction

    function void write_reg(wto_pkg::cfg_index_t idx,
                            logic [wto_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        wto_pkg::CFG_TPM:  tpm = data[15:0];
        wto_pkg::CFG_WB:   wb = data[11:0];
        wto_pkg::CFG_MAXS: max_speed = data[13:0];
        default: ;
      endcase
    endfunction

    // Predict the report for an accepted sample and advance the state
    function void note_sample(logic [31:0] t, logic [31:0] lc, logic [31:0] rc,
                              logic lb, logic rb);
      motion_t      m;
      logic [31:0]  dt;
      logic [31:0]  raw;
      longint       dl, dr, sum, dif;
      logic [127:0] num, den, mag;
      logic [15:0]  tpm_eff;
      logic [11:0]  wb_eff;
      logic         inexact;
      m.status = wto_pkg::ST_STORED;
      m.speed  = '0;
      m.turn   = '0;
      dt = t - last_time;
      if (!have_prev) begin
        have_prev  = 1'b1;
        last_time  = t;
        last_left  = lc;
        last_right = rc;
      end else if (dt == 0 || dt[31]) begin
        m.status = wto_pkg::ST_DT_BAD;
      end else begin
        // a zero register reads as one
        tpm_eff = (tpm == 0) ? 16'd1 : tpm;
        wb_eff  = (wb == 0) ? 12'd1 : wb;
        raw = lc - last_left;
        dl  = longint'($signed(raw));
        raw = rc - last_right;
        dr  = longint'($signed(raw));
        if (lb) dl = -dl;
        if (rb) dr = -dr;
        rev        = lb & rb;
        last_time  = t;
        last_left  = lc;
        last_right = rc;
        // exact speed magnitude against the limit, remainder breaks a tie
        sum = dl + dr;
        num = 128'((sum < 0) ? -sum : sum) * 128'd1000000000;
        den = 128'(dt) * 128'(tpm_eff) * 128'd2;
        mag = num / den;
        inexact = (num % den) != 0;
        if (mag > 128'(max_speed) || (mag == 128'(max_speed) && inexact)) begin
          m.status = wto_pkg::ST_FAST;
        end else begin
          m.status = wto_pkg::ST_VALID;
          m.speed  = (sum < 0) ? wto_pkg::SPEED_W'(-mag) : wto_pkg::SPEED_W'(mag);
          dif = dr - dl;
          num = 128'((dif < 0) ? -dif : dif) * 128'd1000000000000;
          den = 128'(dt) * 128'(tpm_eff) * 128'(wb_eff);
          mag = num / den;
          // saturate turn rate at its signed range
          if (dif < 0) begin
            if (mag > 128'(wto_pkg::TURN_NEG_CAP)) mag = 128'(wto_pkg::TURN_NEG_CAP);
            m.turn = wto_pkg::TURN_W'(-mag);
          end else begin
            if (mag > 128'(wto_pkg::TURN_POS_CAP)) mag = 128'(wto_pkg::TURN_POS_CAP);
            m.turn = wto_pkg::TURN_W'(mag);
          end
        end
      end
      m.reversing = rev;
      status_seen[int'(m.status)]++;
      expected_motion.push_back(m);
    endfunction

    // Compare an accepted report with the oldest prediction
    function void check_report(logic [1:0] st, logic [wto_pkg::SPEED_W-1:0] sp,
                               logic [wto_pkg::TURN_W-1:0] tr, logic rv);
      motion_t m;
      if (expected_motion.size() == 0) begin
        errors++;
        $display("%0t: unexpected report, status %0d speed %0d turn %0d", $time, st,
                 $signed(sp), $signed(tr));
        return;
      end
      m = expected_motion.pop_front();
      if (st !== m.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, m.status, st);
      end
      if (sp !== m.speed) begin
        errors++;
        $display("%0t: speed_mm_s expected %0d actual %0d", $time, $signed(m.speed),
                 $signed(sp));
      end
      if (tr !== m.turn) begin
        errors++;
        $display("%0t: turn_rate_mrad_s expected %0d actual %0d", $time,
                 $signed(m.turn), $signed(tr));
      end
      if (rv !== m.reversing) begin
        errors++;
        $display("%0t: reversing expected %0d actual %0d", $time, m.reversing, rv);
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_stall;
  logic [31:0]                    time_us;
  logic [31:0]                    left_count;
  logic [31:0]                    right_count;
  logic                           left_backward;
  logic                           right_backward;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [1:0]                     status;
  logic [wto_pkg::SPEED_W-1:0]    speed_mm_s;
  logic [wto_pkg::TURN_W-1:0]     turn_rate_mrad_s;
  logic                           reversing;
  logic                           cfg_write;
  logic [wto_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [wto_pkg::CFG_DATA_W-1:0] cfg_data;

  odometry_board board;
  logic          quiet;
  int            hold_left = 0;
  int            idle_cycles = 0;
  int            settings_used;

  wheel_tick_odometry dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .time_us          (time_us),
    .left_count       (left_count),
    .right_count      (right_count),
    .left_backward    (left_backward),
    .right_backward   (right_backward),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .speed_mm_s       (speed_mm_s),
    .turn_rate_mrad_s (turn_rate_mrad_s),
    .reversing        (reversing),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #10 clk = ~clk;

  // Idle length per word: often none, sometimes long
  function automatic int draw_gap();
    if (quiet) return 0;
    case ($urandom_range(0, 3))
      0, 1: return 0;
      2: return $urandom_range(1, 4);
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  function automatic longint spread(longint m);
    return longint'($urandom_range(0, 32'(2 * m))) - m;
  endfunction

  // Take reports, then hold stall for a drawn number of cycles
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      board.check_report(status, speed_mm_s, turn_rate_mrad_s, reversing);
      hold_left = draw_gap();
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Abort when neither side moves a word for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("wheel_tick_odometry: mismatch");
      $finish;
    end
  end

  // Present one sample and hold it until accepted
  task automatic send_word(input logic [31:0] t, input logic [31:0] l,
                           input logic [31:0] r, input logic lb, input logic rb);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    time_us        <= t;
    left_count     <= l;
    right_count    <= r;
    left_backward  <= lb;
    right_backward <= rb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_sample(t, l, r, lb, rb);
  endtask

  // Sample relative to the stored time and counts
  task automatic send_rel(input logic [31:0] dt, input logic [31:0] raw_l,
                          input logic [31:0] raw_r, input logic lb, input logic rb);
    send_word(board.last_time + dt, board.last_left + raw_l, board.last_right + raw_r,
              lb, rb);
  endtask

  // Drop valid and wait until every report has come back
  task automatic drain_block(input int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (board.expected_motion.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic load_settings(input logic [15:0] tpm, input logic [15:0] wb,
                               input logic [15:0] ms);
    cfg_write <= 1'b1;
    cfg_index <= wto_pkg::CFG_TPM;
    cfg_data  <= tpm;
    @(posedge clk);
    board.write_reg(wto_pkg::CFG_TPM, tpm);
    cfg_index <= wto_pkg::CFG_WB;
    cfg_data  <= wb;
    @(posedge clk);
    board.write_reg(wto_pkg::CFG_WB, wb);
    cfg_index <= wto_pkg::CFG_MAXS;
    cfg_data  <= ms;
    @(posedge clk);
    board.write_reg(wto_pkg::CFG_MAXS, ms);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // Mostly plausible motion with random content, plus noise and bad timestamps
  task automatic send_random();
    int           pick;
    logic [31:0]  dt;
    logic         lb, rb;
    logic [127:0] span;
    longint       lim, dl, dr, base, spin;
    pick = $urandom_range(0, 99);
    lb   = 1'($urandom_range(0, 1));
    rb   = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: dt = $urandom_range(1, 1000);
      1, 2: dt = $urandom_range(1000, 200000);
      default: dt = {1'b0, 31'($urandom())} | 32'd1;
    endcase
    // largest tick sum that stays within the speed limit
    span = 128'(dt) * 128'(board.max_speed) * 128'((board.tpm == 0) ? 16'd1 : board.tpm)
           * 128'd2 / 128'd1000000000;
    lim = (span > 128'(1 << 29)) ? (longint'(1) << 29) : longint'(span);
    if (pick < 15) begin
      send_word($urandom(), $urandom(), $urandom(), lb, rb);
    end else if (pick < 25) begin
      send_rel(($urandom_range(0, 2) == 0) ? 32'd0 : {1'b1, 31'($urandom())},
               $urandom_range(0, 64), $urandom_range(0, 64), lb, rb);
    end else begin
      if (pick < 40) begin
        // overspeed: both wheels past half the limit
        dl = lim / 2 + 1 + longint'($urandom_range(0, 1000));
        if ($urandom_range(0, 1) == 1) dl = -dl;
        dr = dl;
      end else begin
        base = spread(lim / 2);
        if (pick >= 90) base = ($urandom_range(0, 1) == 1) ? lim / 2 : -(lim / 2);
        spin = spread((pick < 60) ? (longint'(1) << 24) : 64);
        dl = base - spin;
        dr = base + spin;
      end
      send_rel(dt, 32'(lb ? -dl : dl), 32'(rb ? -dr : dr), lb, rb);
    end
  endtask

  initial begin
    int phase;
    int i;
    board          = new();
    clk            = 1'b0;
    rst            = 1'b1;
    in_valid       = 1'b0;
    time_us        = '0;
    left_count     = '0;
    right_count    = '0;
    left_backward  = 1'b0;
    right_backward = 1'b0;
    cfg_write      = 1'b0;
    cfg_index      = wto_pkg::CFG_TPM;
    cfg_data       = '0;
    quiet          = 1'b0;
    settings_used  = 1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // first sample after reset, counters near wrap, default registers
    send_word(32'hFFFF_FF00, 32'hFFFF_FFF0, 32'h0000_0010, 1'b0, 1'b0);
    repeat (20) send_random();
    drain_block(SETTLE_CYCLES);

    // directed cases with round register values
    load_settings(16'd1000, 16'd500, 16'd1000);
    send_rel(32'd0, 32'd5, 32'd5, 1'b0, 1'b0);
    send_rel(32'h8000_0000, 32'd1, 32'd1, 1'b0, 1'b0);
    send_rel(32'hFFFF_FFFF, 32'd1, 32'd1, 1'b0, 1'b0);
    send_rel(32'd1000, 32'd1, 32'd1, 1'b0, 1'b0);
    send_rel(32'd1000, 32'd2, 32'd2, 1'b0, 1'b0);
    send_rel(32'd1000000, 32'd1000, 32'd1001, 1'b0, 1'b0);
    send_rel(32'd1000000, 32'(-1000), 32'(-1000), 1'b0, 1'b0);
    send_rel(32'd1, 32'd1000, 32'd1000, 1'b1, 1'b0);
    send_rel(32'd1, 32'd1000, 32'd1000, 1'b0, 1'b1);
    send_rel(32'd1000000, 32'd5, 32'd5, 1'b1, 1'b1);
    send_rel(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0);
    send_rel(32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1);
    send_rel(32'd1000000, 32'd3, 32'd7, 1'b0, 1'b0);
    send_rel(32'd1000000, 32'd1, 32'(-1), 1'b0, 1'b0);
    send_word(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_word(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1);
    send_rel(32'd2, 32'd0, 32'd0, 1'b0, 1'b0);

    // random phases across register extremes
    for (phase = 0; phase < 8; phase++) begin
      drain_block(SETTLE_CYCLES);
      case (phase)
        0: load_settings(16'd280, 16'd330, 16'd1000);
        1: load_settings(16'd1, 16'd1, 16'd1);
        2: load_settings(16'd65535, 16'd4000, 16'd10000);
        3: load_settings(16'd0, 16'd0, 16'd16383);
        4: load_settings(16'd65535, 16'd1, 16'd1);
        5: load_settings(16'd1, 16'd4095, 16'd10000);
        6: load_settings(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 4000)),
                         16'($urandom_range(1, 10000)));
        default: load_settings(16'($urandom_range(1, 2000)),
                               16'($urandom_range(1, 4000)),
                               16'($urandom_range(1, 10000)));
      endcase
      quiet = (phase % 3 == 1);
      for (i = 0; i < PHASE_WORDS; i++) begin
        // on even phases, hold off mid-phase until the pipeline is empty
        if (i == PHASE_WORDS / 2 && phase % 2 == 0) drain_block(0);
        send_random();
      end
    end

    quiet = 1'b0;
    drain_block(TAIL_CYCLES);
    $display("ran %0d samples under %0d register settings", board.status_seen[0] +
             board.status_seen[1] + board.status_seen[2] + board.status_seen[3],
             settings_used);
    $display("reports: %0d stored, %0d valid, %0d bad dt, %0d overspeed",
             board.status_seen[0], board.status_seen[1], board.status_seen[2],
             board.status_seen[3]);
    if (board.errors == 0 && board.expected_motion.size() == 0) begin
      $display("wheel_tick_odometry: match");
    end else begin
      $display("wheel_tick_odometry: mismatch");
    end
    $finish;
  end

endmodule
